[rtl/core/mstg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_pkg: shared types and constants of the morse symbol tone generator
// register map, segment kinds, controller/datapath bundles and sine table math
// ----------------------------------------------------------------------------
package mstg_pkg;

	// default build parameters
	localparam int SINE_DEPTH_DEF = 1024;
	localparam int COUNT_W_DEF    = 16;

	// fixed field widths
	localparam int LEN_W   = 16;
	localparam int PHASE_W = 32;
	localparam int GAIN_W  = 15;
	localparam int SMP_W   = 16;
	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int REG_W   = 3;

	// register reset values
	localparam logic [LEN_W-1:0]   DASH_RST  = 16'd13230;
	localparam logic [LEN_W-1:0]   DOT_RST   = 16'd4410;
	localparam logic [LEN_W-1:0]   GAP_RST   = 16'd13230;
	localparam logic [LEN_W-1:0]   SPACE_RST = 16'd4410;
	localparam logic [PHASE_W-1:0] STEP_RST  = 32'd97391549;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 15'd32760;

	// register indexes (byte address = 4 * index)
	typedef enum logic [REG_W-1:0] {
		REG_DASH       = 3'd0,
		REG_DOT        = 3'd1,
		REG_GAP        = 3'd2,
		REG_SPACE      = 3'd3,
		REG_PHASE_STEP = 3'd4,
		REG_MAX_GAIN   = 3'd5
	} mstg_reg_t;

	// character codes and word functions
	localparam logic [CHAR_W-1:0] CHAR_DASH = 8'd45;
	localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'd46;
	localparam logic FUNC_OFFER = 1'b0;
	localparam logic FUNC_TICK  = 1'b1;

	// segment being played
	typedef enum logic [1:0] {
		KIND_IDLE  = 2'd0,
		KIND_TONE  = 2'd1,
		KIND_GAP   = 2'd2,
		KIND_SPACE = 2'd3
	} mstg_kind_t;

	// configuration bundle
	typedef struct packed {
		logic [LEN_W-1:0]   dash_samples;
		logic [LEN_W-1:0]   dot_samples;
		logic [LEN_W-1:0]   gap_samples;
		logic [LEN_W-1:0]   space_samples;
		logic [PHASE_W-1:0] phase_step;
		logic [GAIN_W-1:0]  max_gain;
	} mstg_cfg_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch;
		logic eval;
		logic div_step;
		logic mul_left;
		logic mul_right;
		logic commit;
	} mstg_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic tone_tick;
		logic out_free;
	} mstg_sts_t;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	// taylor term divide, constant divisors only
	function automatic longint unsigned taylor_div(input longint unsigned t, input int n);
		longint unsigned q;
		case (n)
			1:       q = t / 6;
			2:       q = t / 20;
			3:       q = t / 42;
			4:       q = t / 72;
			5:       q = t / 110;
			default: q = t / 156;
		endcase
		return q;
	endfunction

	// q1.15 sine of table entry k, table of 2^aw entries, evaluated at elaboration
	function automatic logic signed [SMP_W-1:0] sine_entry(input int unsigned k,
		input int unsigned aw);
		longint unsigned turn;
		longint unsigned r;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint sum;
		logic [1:0] quad;
		turn = 64'(k) << (32 - aw);
		quad = 2'(turn >> 30);
		r    = turn & 64'h3FFF_FFFF;
		if (quad[0]) begin
			r = (64'd1 << 30) - r;
		end
		x    = (r * HALF_PI_Q30) >> 30;
		x2   = (x * x) >> 30;
		term = x;
		sum  = longint'(x);
		for (int n = 1; n <= 6; n++) begin
			term = (term * x2) >> 30;
			term = taylor_div(term, n);
			if (n % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		v = (longint'(sum) + 64'd16384) >> 15;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return quad[1] ? -SMP_W'(v) : SMP_W'(v);
	endfunction

endpackage
`default_nettype wire

[rtl/core/mstg_regs.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_regs: configuration register file
// apb-style write and read of the six timing, tone and gain registers
// ----------------------------------------------------------------------------
module mstg_regs
	import mstg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output mstg_cfg_t              cfg
);

	mstg_cfg_t       cfg_q;
	logic            wr_en;
	logic [REG_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dash_samples  <= DASH_RST;
			cfg_q.dot_samples   <= DOT_RST;
			cfg_q.gap_samples   <= GAP_RST;
			cfg_q.space_samples <= SPACE_RST;
			cfg_q.phase_step    <= STEP_RST;
			cfg_q.max_gain      <= GAIN_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_DASH:       cfg_q.dash_samples  <= pwdata[LEN_W-1:0];
				REG_DOT:        cfg_q.dot_samples   <= pwdata[LEN_W-1:0];
				REG_GAP:        cfg_q.gap_samples   <= pwdata[LEN_W-1:0];
				REG_SPACE:      cfg_q.space_samples <= pwdata[LEN_W-1:0];
				REG_PHASE_STEP: cfg_q.phase_step    <= pwdata[PHASE_W-1:0];
				REG_MAX_GAIN:   cfg_q.max_gain      <= pwdata[GAIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_idx)
			REG_DASH:       prdata = DATA_W'(cfg_q.dash_samples);
			REG_DOT:        prdata = DATA_W'(cfg_q.dot_samples);
			REG_GAP:        prdata = DATA_W'(cfg_q.gap_samples);
			REG_SPACE:      prdata = DATA_W'(cfg_q.space_samples);
			REG_PHASE_STEP: prdata = DATA_W'(cfg_q.phase_step);
			REG_MAX_GAIN:   prdata = DATA_W'(cfg_q.max_gain);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

[rtl/core/mstg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_ctrl: sequencing state machine
// steps one word through decode, for a tone tick also gain divide and two multiplies, and commit
// ----------------------------------------------------------------------------
module mstg_ctrl
	import mstg_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire mstg_sts_t sts,
	output mstg_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_MUL_L,
		ST_MUL_R,
		ST_OUT
	} state_t;

	localparam int CNT_W = $clog2(GAIN_W);

	state_t           state_q;
	logic [CNT_W-1:0] div_cnt_q;
	logic             in_ready_q;

	assign in_ready = in_ready_q;

	// state, step counter and ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			div_cnt_q  <= '0;
			in_ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q    <= ST_EVAL;
						in_ready_q <= 1'b0;
					end
				end
				ST_EVAL: begin
					div_cnt_q <= '0;
					state_q   <= sts.tone_tick ? ST_DIV : ST_OUT;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == CNT_W'(GAIN_W - 1)) begin
						state_q <= ST_MUL_L;
					end
				end
				ST_MUL_L: state_q <= ST_MUL_R;
				ST_MUL_R: state_q <= ST_OUT;
				ST_OUT: begin
					if (sts.out_free) begin
						state_q    <= ST_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_ready_q <= 1'b1;
				end
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd           = '0;
		cmd.latch     = (state_q == ST_IDLE) && in_valid;
		cmd.eval      = (state_q == ST_EVAL);
		cmd.div_step  = (state_q == ST_DIV);
		cmd.mul_left  = (state_q == ST_MUL_L);
		cmd.mul_right = (state_q == ST_MUL_R);
		cmd.commit    = (state_q == ST_OUT) && sts.out_free;
	end

endmodule
`default_nettype wire

[rtl/core/mstg_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_dp: sample datapath
// segment state, sine table, restoring gain divider, shared gain multiplier
// and the output word register
// ----------------------------------------------------------------------------
module mstg_dp
	import mstg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int COUNT_WIDTH      = COUNT_W_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mstg_cfg_t         cfg,
	input  wire mstg_cmd_t         cmd,
	output mstg_sts_t              sts,
	input  wire logic              func,
	input  wire logic [CHAR_W-1:0] symbol_char,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic signed [SMP_W-1:0] left_sample,
	output logic signed [SMP_W-1:0] right_sample,
	output logic                   sample_valid,
	output logic                   symbol_accepted,
	output logic                   busy_res
);

	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam int CW = COUNT_WIDTH;
	localparam int PW = CW + GAIN_W;

	// word registers
	logic              func_q;
	logic [CHAR_W-1:0] char_q;

	// segment state
	mstg_kind_t        kind_q;
	logic [CW-1:0]     index_q;
	logic [CW-1:0]     len_q;
	logic [PHASE_W-1:0] phase_q;

	// arithmetic registers
	logic signed [SMP_W-1:0] sine_q;
	logic [CW-1:0]           rem_q;
	logic [GAIN_W-1:0]       quo_q;
	logic signed [SMP_W-1:0] left_q;
	logic signed [SMP_W-1:0] right_q;

	// output word register
	logic                    out_valid_q;
	logic signed [SMP_W-1:0] left_out_q;
	logic signed [SMP_W-1:0] right_out_q;
	logic                    smp_valid_out_q;
	logic                    accepted_out_q;
	logic                    busy_out_q;

	// sine table, built at elaboration
	logic signed [SMP_W-1:0] sine_rom [SINE_TABLE_DEPTH];
	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam logic signed [SMP_W-1:0] ENTRY = sine_entry(k, AW);
		assign sine_rom[k] = ENTRY;
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			sine_q <= sine_rom[phase_q[PHASE_W-1 -: AW]];
		end
	end

	// latch the incoming word
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q <= func;
			char_q <= symbol_char;
		end
	end

	assign sts.tone_tick = (func_q == FUNC_TICK) && (kind_q == KIND_TONE) && (len_q != '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	// gain divider: index * max_gain / length, one quotient bit per step
	logic [PW-1:0] gain_prod;
	logic [CW:0]   div_trial;
	logic          div_ge;

	assign gain_prod = PW'(index_q) * PW'(cfg.max_gain);
	assign div_trial = {rem_q, quo_q[GAIN_W-1]};
	assign div_ge    = div_trial >= {1'b0, len_q};

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			rem_q <= gain_prod[PW-1:GAIN_W];
			quo_q <= gain_prod[GAIN_W-1:0];
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? CW'(div_trial - {1'b0, len_q}) : div_trial[CW-1:0];
			quo_q <= {quo_q[GAIN_W-2:0], div_ge};
		end
	end

	// shared gain multiplier: left gain first, then right gain
	logic [GAIN_W-1:0]   gain_op;
	logic [SMP_W-1:0]    sine_neg;
	logic [GAIN_W-1:0]   sine_mag;
	logic [2*GAIN_W-1:0] mul_prod;
	logic [SMP_W-1:0]    scaled_mag;
	logic signed [SMP_W-1:0] scaled;

	assign gain_op    = cmd.mul_right ? GAIN_W'(cfg.max_gain - quo_q) : quo_q;
	assign sine_neg   = -sine_q;
	assign sine_mag   = sine_q[SMP_W-1] ? sine_neg[GAIN_W-1:0] : sine_q[GAIN_W-1:0];
	assign mul_prod   = gain_op * sine_mag;
	assign scaled_mag = {1'b0, mul_prod[2*GAIN_W-1:GAIN_W]};
	assign scaled     = sine_q[SMP_W-1] ? -scaled_mag : scaled_mag;

	always_ff @(posedge clk) begin
		if (cmd.mul_left) begin
			left_q <= scaled;
		end
		if (cmd.mul_right) begin
			right_q <= scaled;
		end
	end

	// next segment state and result word
	mstg_kind_t         kind_n;
	logic [CW-1:0]      index_n;
	logic [CW-1:0]      len_n;
	logic [PHASE_W-1:0] phase_n;
	logic [CW-1:0]      index_inc;
	logic [CW-1:0]      space_len;
	logic               acc_n;
	logic               valid_n;

	assign index_inc = index_q + 1'b1;
	assign space_len = CW'(cfg.space_samples);

	always_comb begin
		kind_n  = kind_q;
		index_n = index_q;
		len_n   = len_q;
		phase_n = phase_q;
		acc_n   = 1'b0;
		valid_n = 1'b0;
		if (func_q == FUNC_OFFER) begin
			if (kind_q == KIND_IDLE) begin
				acc_n   = 1'b1;
				index_n = '0;
				phase_n = '0;
				if (char_q == CHAR_DASH) begin
					kind_n = KIND_TONE;
					len_n  = CW'(cfg.dash_samples);
				end else if (char_q == CHAR_DOT) begin
					kind_n = KIND_TONE;
					len_n  = CW'(cfg.dot_samples);
				end else begin
					kind_n = KIND_GAP;
					len_n  = CW'(cfg.gap_samples);
				end
				// empty tone or gap goes straight to the trailing space
				if (len_n == '0) begin
					len_n  = space_len;
					kind_n = (space_len == '0) ? KIND_IDLE : KIND_SPACE;
				end
			end
		end else if ((kind_q != KIND_IDLE) && (len_q != '0)) begin
			valid_n = 1'b1;
			phase_n = phase_q + cfg.phase_step;
			index_n = index_inc;
			if (index_inc >= len_q) begin
				index_n = '0;
				phase_n = '0;
				if (kind_q == KIND_SPACE) begin
					kind_n = KIND_IDLE;
					len_n  = '0;
				end else begin
					len_n  = space_len;
					kind_n = (space_len == '0) ? KIND_IDLE : KIND_SPACE;
				end
			end
		end else if (kind_q != KIND_IDLE) begin
			kind_n = KIND_IDLE;
		end
	end

	// segment state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= KIND_IDLE;
			index_q <= '0;
			len_q   <= '0;
			phase_q <= '0;
		end else if (cmd.commit) begin
			kind_q  <= kind_n;
			index_q <= index_n;
			len_q   <= len_n;
			phase_q <= phase_n;
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			left_out_q      <= sts.tone_tick ? left_q : '0;
			right_out_q     <= sts.tone_tick ? right_q : '0;
			smp_valid_out_q <= valid_n;
			accepted_out_q  <= acc_n;
			busy_out_q      <= (kind_n != KIND_IDLE);
		end
	end

	assign out_valid       = out_valid_q;
	assign left_sample     = left_out_q;
	assign right_sample    = right_out_q;
	assign sample_valid    = smp_valid_out_q;
	assign symbol_accepted = accepted_out_q;
	assign busy_res        = busy_out_q;

endmodule
`default_nettype wire

[rtl/core/morse_symbol_tone_generator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// morse_symbol_tone_generator: morse character to stereo tone samples
// Each input word either offers a character (func 0) or is one sample tick
// (func 1), and each word yields exactly one output word. While idle an offered
// '-' or '.' starts a sine tone of the dash or dot length, any other byte a
// silence of the gap length; every character then ends with the space silence.
// Ticks give one stereo sample of the running segment, panned from right to
// left across the tone; silence gives zero samples. An offer or a tick during
// idle or silence goes from acceptance through evaluate and output to the next
// acceptance; a tone tick also runs the 15-step restoring divider that computes
// the pan gain and the two passes through the shared gain multiplier. A new word
// is accepted while the previous output word still waits to be taken; a
// finished word holds in the datapath until the output register frees. The sine
// table is a constant built at elaboration, so no clearing pass follows reset.
// Registers sit on the APB port at byte address 4 * index.
// ----------------------------------------------------------------------------
module morse_symbol_tone_generator
	import mstg_pkg::*;
#(
	parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEF,
	parameter int COUNT_WIDTH      = COUNT_W_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic      [DATA_W-1:0]  prdata,
	output logic                    pready,
	// input words
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [CHAR_W-1:0]  symbol_char,
	// output words
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [SMP_W-1:0] left_sample,
	output logic signed [SMP_W-1:0] right_sample,
	output logic                    sample_valid,
	output logic                    symbol_accepted,
	output logic                    busy_res
);

	mstg_cfg_t cfg;
	mstg_cmd_t cmd;
	mstg_sts_t sts;

	// register file
	mstg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	mstg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	mstg_dp #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.COUNT_WIDTH      (COUNT_WIDTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.cmd             (cmd),
		.sts             (sts),
		.func            (func),
		.symbol_char     (symbol_char),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.left_sample     (left_sample),
		.right_sample    (right_sample),
		.sample_valid    (sample_valid),
		.symbol_accepted (symbol_accepted),
		.busy_res        (busy_res)
	);

endmodule
`default_nettype wire

[rtl/core/mstg_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mstg_checker: port-level checks of the tone generator
// watches handshakes and output word consistency, bound to the top level
// ----------------------------------------------------------------------------
module mstg_checker
	import mstg_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_ready,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [SMP_W-1:0]   left_sample,
	input wire logic [SMP_W-1:0]   right_sample,
	input wire logic               sample_valid,
	input wire logic               symbol_accepted,
	input wire logic               busy_res
);

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_sample)
			&& $stable(right_sample) && $stable(sample_valid)
			&& $stable(symbol_accepted) && $stable(busy_res))
		else $error("output word changed while stalled");

	// one word in flight: ready drops after an accept
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again before the word was processed");

	// a word is either an accepted character or a sample, never both
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(sample_valid && symbol_accepted))
		else $error("sample and character acceptance in one word");

	// no sample means silent channels
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !sample_valid |-> left_sample == '0 && right_sample == '0)
		else $error("nonzero audio without a sample");

endmodule

bind morse_symbol_tone_generator mstg_checker u_checker (.*);
`default_nettype wire

[sim/tb_morse_symbol_tone_generator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_morse_symbol_tone_generator: self-checking testbench of the tone generator
// Character offers and sample ticks go in over the valid/ready input channel.
// The timing, pitch and gain registers are programmed over APB between phases.
// Every output word is checked against a scoreboard that mirrors the player.
// Both channels idle at random, and some stretches have no idling at all.
// ----------------------------------------------------------------------------
module tb_morse_symbol_tone_generator;
	import mstg_pkg::*;

	localparam int CLK_PERIOD     = 4;
	localparam int RESET_CYCLES   = 7;
	localparam int TABLE_DEPTH    = 1024;
	localparam int TABLE_SHIFT    = 22;     // 32 - log2(TABLE_DEPTH)
	localparam int COUNT_BITS     = 16;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_WORDS    = 135;
	localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;

	// one output word
	typedef struct packed {
		logic signed [SMP_W-1:0] left_val;
		logic signed [SMP_W-1:0] right_val;
		logic                    smp_valid;
		logic                    accepted;
		logic                    busy;
	} tone_word_t;

	// mirror of the player plus the queue of words still to come out
	class tone_scoreboard;
		logic [LEN_W-1:0]        dash_len;
		logic [LEN_W-1:0]        dot_len;
		logic [LEN_W-1:0]        gap_len;
		logic [LEN_W-1:0]        space_len;
		logic [PHASE_W-1:0]      step;
		logic [GAIN_W-1:0]       gain;
		mstg_kind_t              kind;
		logic [LEN_W-1:0]        pos;
		logic [LEN_W-1:0]        seg_len;
		logic [PHASE_W-1:0]      phase;
		logic signed [SMP_W-1:0] sine_tab[TABLE_DEPTH];
		tone_word_t              sample_queue[$];
		int                      errors;

		function new();
			int k;
			dash_len  = 16'd13230;
			dot_len   = 16'd4410;
			gap_len   = 16'd13230;
			space_len = 16'd4410;
			step      = 32'd97391549;
			gain      = 15'd32760;
			kind      = KIND_IDLE;
			pos       = '0;
			seg_len   = '0;
			phase     = '0;
			errors    = 0;
			for (k = 0; k < TABLE_DEPTH; k++) begin
				sine_tab[k] = sine_value(k);
			end
		endfunction

		// q1.15 sine of entry k: quadrant fold, then a q30 taylor series
		function logic signed [SMP_W-1:0] sine_value(int k);
			longint unsigned turn;
			longint unsigned r;
			longint unsigned x;
			longint unsigned x2;
			longint unsigned term;
			longint unsigned div;
			longint          acc;
			longint          v;
			int              quad;
			int              n;
			turn = longint'(k) << TABLE_SHIFT;
			quad = int'((turn >> 30) & 64'd3);
			r    = turn & 64'h3FFF_FFFF;
			if (quad % 2 == 1) begin
				r = (64'd1 << 30) - r;
			end
			x    = (r * QUARTER_TURN_Q30) >> 30;
			x2   = (x * x) >> 30;
			term = x;
			acc  = longint'(x);
			for (n = 1; n <= 6; n++) begin
				term = (term * x2) >> 30;
				div  = longint'((2 * n) * (2 * n + 1));
				term = term / div;
				if (n % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = (acc + 16384) >>> 15;
			if (v > 32767) begin
				v = 32767;
			end
			return (quad >= 2) ? SMP_W'(-v) : SMP_W'(v);
		endfunction

		// gain times sample over 2^15, truncated toward zero
		function logic signed [SMP_W-1:0] pan_scale(logic [GAIN_W-1:0] g,
			logic signed [SMP_W-1:0] s);
			int unsigned mag;
			int unsigned prod;
			mag  = (s < 0) ? 32'(-int'(s)) : 32'(int'(s));
			prod = (32'(g) * mag) >> 15;
			return (s < 0) ? -SMP_W'(prod) : SMP_W'(prod);
		endfunction

		function void set_reg(mstg_reg_t idx, logic [DATA_W-1:0] val);
			case (idx)
				REG_DASH:       dash_len  = val[LEN_W-1:0];
				REG_DOT:        dot_len   = val[LEN_W-1:0];
				REG_GAP:        gap_len   = val[LEN_W-1:0];
				REG_SPACE:      space_len = val[LEN_W-1:0];
				REG_PHASE_STEP: step      = val[PHASE_W-1:0];
				REG_MAX_GAIN:   gain      = val[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		// trailing silence, skipped when its length is zero
		function void begin_space();
			seg_len = space_len;
			pos     = '0;
			phase   = '0;
			if (space_len == 0) begin
				kind = KIND_IDLE;
			end else begin
				kind = KIND_SPACE;
			end
		endfunction

		// note an accepted input word; returns 1 when it did something
		function bit note_word(logic f, logic [CHAR_W-1:0] ch);
			tone_word_t              w;
			logic signed [SMP_W-1:0] s;
			logic [GAIN_W-1:0]       gl;
			logic [GAIN_W-1:0]       gr;
			w = '0;
			if (f == FUNC_OFFER) begin
				if (kind == KIND_IDLE) begin
					w.accepted = 1'b1;
					if (ch == CHAR_DASH) begin
						kind    = KIND_TONE;
						seg_len = dash_len;
					end else if (ch == CHAR_DOT) begin
						kind    = KIND_TONE;
						seg_len = dot_len;
					end else begin
						kind    = KIND_GAP;
						seg_len = gap_len;
					end
					pos   = '0;
					phase = '0;
					if (seg_len == 0) begin
						begin_space();
					end
				end
			end else if (kind != KIND_IDLE && seg_len != 0) begin
				w.smp_valid = 1'b1;
				if (kind == KIND_TONE) begin
					s           = sine_tab[phase[PHASE_W-1:TABLE_SHIFT]];
					gl          = GAIN_W'((32'(pos) * 32'(gain)) / 32'(seg_len));
					gr          = gain - gl;
					w.left_val  = pan_scale(gl, s);
					w.right_val = pan_scale(gr, s);
				end
				phase = phase + step;
				pos   = pos + 1'b1;
				if (pos >= seg_len) begin
					if (kind == KIND_SPACE) begin
						kind    = KIND_IDLE;
						pos     = '0;
						seg_len = '0;
						phase   = '0;
					end else begin
						begin_space();
					end
				end
			end else if (kind != KIND_IDLE) begin
				kind = KIND_IDLE;
			end
			w.busy = (kind != KIND_IDLE);
			sample_queue.push_back(w);
			return w.accepted || w.smp_valid;
		endfunction

		function void check_field(string name, int want_v, int got_v);
			if (want_v != got_v) begin
				errors++;
				$error("%s: expected %0d, got %0d", name, want_v, got_v);
			end
		endfunction

		// compare an accepted output word with the oldest expected one
		function void check_word(tone_word_t got);
			tone_word_t want;
			if (sample_queue.size() == 0) begin
				errors++;
				$error("output word arrived with no expected word waiting");
				return;
			end
			want = sample_queue.pop_front();
			check_field("left_sample", int'(want.left_val), int'(got.left_val));
			check_field("right_sample", int'(want.right_val), int'(got.right_val));
			check_field("sample_valid", int'(want.smp_valid), int'(got.smp_valid));
			check_field("symbol_accepted", int'(want.accepted), int'(got.accepted));
			check_field("busy_res", int'(want.busy), int'(got.busy));
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_ready;
	logic                    func;
	logic [CHAR_W-1:0]       symbol_char;
	logic                    out_valid;
	logic                    out_ready;
	logic signed [SMP_W-1:0] left_sample;
	logic signed [SMP_W-1:0] right_sample;
	logic                    sample_valid;
	logic                    symbol_accepted;
	logic                    busy_res;

	tone_scoreboard sb;
	bit             in_held;
	bit             send_quiet;
	bit             recv_quiet;
	int             useful_words;

	morse_symbol_tone_generator #(
		.SINE_TABLE_DEPTH(TABLE_DEPTH),
		.COUNT_WIDTH     (COUNT_BITS)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.func           (func),
		.symbol_char    (symbol_char),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.left_sample    (left_sample),
		.right_sample   (right_sample),
		.sample_valid   (sample_valid),
		.symbol_accepted(symbol_accepted),
		.busy_res       (busy_res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// send one input word; valid stays up across back-to-back words
	task automatic send_word(logic f, logic [CHAR_W-1:0] ch);
		int gap;
		if ($urandom_range(0, 63) == 0) begin
			send_quiet = !send_quiet;
		end
		gap = send_quiet ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			if (in_held) begin
				in_valid <= 1'b0;
				in_held = 1'b0;
			end
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		func        <= f;
		symbol_char <= ch;
		do @(posedge clk); while (!in_ready);
		in_held = 1'b1;
		if (sb.note_word(f, ch)) begin
			useful_words++;
		end
	endtask

	task automatic lower_input();
		if (in_held) begin
			in_valid <= 1'b0;
			in_held = 1'b0;
		end
	endtask

	// wait for every expected word, then a short pause
	task automatic settle();
		lower_input();
		while (sb.sample_queue.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// apb write: setup and access phases, then idle
	task automatic write_reg(mstg_reg_t idx, logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.set_reg(idx, val);
		@(posedge clk);
	endtask

	// segment length: mostly short, sometimes zero or a few hundred
	function automatic logic [DATA_W-1:0] draw_length();
		int pick;
		logic [LEN_W-1:0] len;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			len = '0;
		end else if (pick == 1) begin
			len = LEN_W'($urandom_range(100, 400));
		end else if (pick == 2) begin
			len = 16'd1;
		end else begin
			len = LEN_W'($urandom_range(1, 12));
		end
		return {16'($urandom), len};
	endfunction

	function automatic logic [CHAR_W-1:0] draw_char();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 4) begin
			return CHAR_DASH;
		end else if (pick < 7) begin
			return CHAR_DOT;
		end
		return CHAR_W'($urandom_range(0, 255));
	endfunction

	task automatic program_random();
		int pick;
		write_reg(REG_DASH, draw_length());
		write_reg(REG_DOT, draw_length());
		write_reg(REG_GAP, draw_length());
		pick = $urandom_range(0, 9);
		write_reg(REG_SPACE, (pick < 3) ? 32'd0 : 32'($urandom_range(1, 8)));
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			write_reg(REG_PHASE_STEP, 32'd0);
		end else if (pick == 1) begin
			write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		end else begin
			write_reg(REG_PHASE_STEP, $urandom());
		end
		pick = $urandom_range(0, 7);
		if (pick == 0) begin
			write_reg(REG_MAX_GAIN, {17'($urandom_range(0, 131071)), 15'd0});
		end else if (pick == 1) begin
			write_reg(REG_MAX_GAIN, 32'd32767);
		end else begin
			write_reg(REG_MAX_GAIN, {17'($urandom), 15'($urandom_range(0, 32767))});
		end
	endtask

	// output side: random stalls, check each accepted word
	initial begin : sink
		int         stall;
		tone_word_t got;
		wait (arst_n === 1'b1);
		forever begin
			if ($urandom_range(0, 63) == 0) begin
				recv_quiet = !recv_quiet;
			end
			stall = recv_quiet ? 0 : $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got.left_val  = left_sample;
			got.right_val = right_sample;
			got.smp_valid = sample_valid;
			got.accepted  = symbol_accepted;
			got.busy      = busy_res;
			sb.check_word(got);
		end
	end

	// watchdog on cycles with no word moving on either channel
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("morse_symbol_tone_generator test failed");
		$finish;
	end

	initial begin : stimulus
		int phase_idx;
		int pick;
		sb = new();
		arst_n      <= 1'b0;
		psel        <= 1'b0;
		penable     <= 1'b0;
		pwrite      <= 1'b0;
		paddr       <= '0;
		pwdata      <= '0;
		in_valid    <= 1'b0;
		func        <= FUNC_OFFER;
		symbol_char <= '0;
		out_ready   <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tick while idle under the reset settings
		send_word(FUNC_TICK, CHAR_DASH);
		settle();
		write_reg(REG_DASH, 32'd3);
		write_reg(REG_DOT, 32'd2);
		write_reg(REG_GAP, 32'd2);
		write_reg(REG_SPACE, 32'd1);
		write_reg(REG_PHASE_STEP, 32'h5555_5555);
		write_reg(REG_MAX_GAIN, 32'd32767);

		// dash, an offer while busy, first tone sample
		send_word(FUNC_OFFER, CHAR_DASH);
		send_word(FUNC_OFFER, CHAR_DOT);
		send_word(FUNC_TICK, 8'h00);

		// settings changed in the middle of a character
		settle();
		write_reg(REG_SPACE, 32'd2);
		write_reg(REG_MAX_GAIN, 32'd20000);
		write_reg(REG_PHASE_STEP, 32'hC000_0000);
		repeat (4) send_word(FUNC_TICK, 8'hFF);
		send_word(FUNC_TICK, 8'h00);

		// dot, then a gap from a non-morse byte
		send_word(FUNC_OFFER, CHAR_DOT);
		repeat (4) send_word(FUNC_TICK, 8'hAA);
		send_word(FUNC_OFFER, 8'h00);
		repeat (4) send_word(FUNC_TICK, 8'h55);

		// zero lengths: the character is taken and the block is idle at once
		settle();
		write_reg(REG_DASH, 32'd0);
		write_reg(REG_DOT, 32'd0);
		write_reg(REG_GAP, 32'd0);
		write_reg(REG_SPACE, 32'd0);
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_MAX_GAIN, 32'd0);
		send_word(FUNC_OFFER, CHAR_DASH);
		send_word(FUNC_TICK, 8'hFF);

		// random phases: mostly full characters, some noise words
		for (phase_idx = 0; phase_idx < RANDOM_PHASES; phase_idx++) begin
			settle();
			program_random();
			useful_words = 0;
			while (useful_words < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if ((sb.kind != KIND_IDLE) == (pick < 85)) begin
					send_word(FUNC_TICK, CHAR_W'($urandom()));
				end else begin
					send_word(FUNC_OFFER, draw_char());
				end
			end
			if ($urandom_range(0, 1) == 1) begin
				while (sb.kind != KIND_IDLE) send_word(FUNC_TICK, CHAR_W'($urandom()));
			end
		end

		// longest lengths and steepest settings, only the head of a dash
		while (sb.kind != KIND_IDLE) send_word(FUNC_TICK, CHAR_W'($urandom()));
		settle();
		write_reg(REG_DASH, 32'hFFFF_FFFF);
		write_reg(REG_DOT, 32'd65535);
		write_reg(REG_GAP, 32'd65535);
		write_reg(REG_SPACE, 32'd65535);
		write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
		write_reg(REG_MAX_GAIN, 32'hFFFF_FFFF);
		send_word(FUNC_OFFER, CHAR_DASH);
		repeat (24) send_word(FUNC_TICK, CHAR_W'($urandom()));

		settle();
		repeat (40) @(posedge clk);
		if (sb.errors == 0) begin
			$display("morse_symbol_tone_generator test passed");
		end else begin
			$display("morse_symbol_tone_generator test failed");
		end
		$finish;
	end

endmodule
